// ===== hdl/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Types, codes and tag tables shared by the header dimension parser files.
// ----------------------------------------------------------------------------
package whp_pkg;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_WEBP    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  localparam logic [1:0] FMT_VP8  = 2'd0;
  localparam logic [1:0] FMT_VP8L = 2'd1;
  localparam logic [1:0] FMT_VP8X = 2'd2;

  localparam logic [13:0] DIM14_MASK = 14'h3FFF;

  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam logic [4:0] POS_TAG_END   = 5'd11;
  localparam logic [4:0] POS_CHUNK_END = 5'd15;
  localparam logic [4:0] POS_DIMS      = 5'd20;
  localparam logic [4:0] POS_VP8L_DONE = 5'd24;
  localparam logic [4:0] POS_VP8_DONE  = 5'd29;

  localparam logic [7:0] CHR_X     = 8'h58;
  localparam logic [7:0] CHR_L     = 8'h4C;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef struct packed {
    logic [4:0]  byte_position;
    logic        tags_match;
    logic [1:0]  format_code;
    logic [47:0] dims_shift;
    logic        parse_done;
  } state_t;

  localparam state_t STATE_RESET = '{
    byte_position: 5'd0,
    tags_match:    1'b1,
    format_code:   FMT_VP8,
    dims_shift:    48'd0,
    parse_done:    1'b0
  };

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  image_format;
    logic [24:0] image_width;
    logic [24:0] image_height;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } byte_item_t;

  // true when the byte at a header position 0..15 is acceptable
  function automatic logic tag_ok(input logic [3:0] pos, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    case (pos)
      4'd0:    ok = (b == 8'h52);
      4'd1:    ok = (b == 8'h49);
      4'd2:    ok = (b == 8'h46);
      4'd3:    ok = (b == 8'h46);
      4'd8:    ok = (b == 8'h57);
      4'd9:    ok = (b == 8'h45);
      4'd10:   ok = (b == 8'h42);
      4'd11:   ok = (b == 8'h50);
      4'd12:   ok = (b == 8'h56);
      4'd13:   ok = (b == 8'h50);
      4'd14:   ok = (b == 8'h38);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== hdl/whp_if.sv =====
// ----------------------------------------------------------------------------
// whp_if
// Valid/ready channels for the file bytes and for the parse results.
// ----------------------------------------------------------------------------
interface whp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output first_byte,
                  output end_of_file, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input end_of_file, output ready);
endinterface

interface whp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  image_format;
  logic [24:0] image_width;
  logic [24:0] image_height;

  modport source (output valid, output status, output image_format,
                  output image_width, output image_height, input ready);
  modport sink (input valid, input status, input image_format,
                input image_width, input image_height, output ready);
endinterface

// ===== hdl/whp_step.sv =====
// ----------------------------------------------------------------------------
// whp_step
// Combinational parse step: next state and optional result for one byte.
// ----------------------------------------------------------------------------
module whp_step (
  input  whp_pkg::state_t     state,
  input  whp_pkg::byte_item_t item,
  output whp_pkg::state_t     state_next,
  output logic                emit,
  output whp_pkg::result_t    result
);

  whp_pkg::state_t s;
  whp_pkg::state_t upd;
  logic [4:0]  pos;
  logic [31:0] word;
  logic        tags_now;

  always_comb begin
    s = item.first_byte ? whp_pkg::STATE_RESET : state;
    pos = s.byte_position;
    upd = s;
    emit = 1'b0;
    result = '0;

    upd.byte_position = (pos < whp_pkg::POS_MAX) ? pos + 5'd1 : pos;
    tags_now = s.tags_match;
    if (!pos[4] && !whp_pkg::tag_ok(pos[3:0], item.data_byte)) begin
      tags_now = 1'b0;
    end
    upd.tags_match = tags_now;
    if (pos >= whp_pkg::POS_DIMS) begin
      upd.dims_shift = {item.data_byte, s.dims_shift[47:8]};
    end
    word = upd.dims_shift[47:16];

    if (pos == whp_pkg::POS_TAG_END && !tags_now) begin
      emit = 1'b1;
      result.status = whp_pkg::ST_NOT_WEBP;
    end else if (pos == whp_pkg::POS_CHUNK_END &&
                 !(tags_now && (item.data_byte == whp_pkg::CHR_X ||
                                item.data_byte == whp_pkg::CHR_L ||
                                item.data_byte == whp_pkg::CHR_SPACE))) begin
      emit = 1'b1;
      result.status = whp_pkg::ST_UNSUPPORTED;
    end else begin
      if (pos == whp_pkg::POS_CHUNK_END) begin
        unique case (item.data_byte)
          whp_pkg::CHR_X: upd.format_code = whp_pkg::FMT_VP8X;
          whp_pkg::CHR_L: upd.format_code = whp_pkg::FMT_VP8L;
          default:        upd.format_code = whp_pkg::FMT_VP8;
        endcase
      end
      if (upd.format_code == whp_pkg::FMT_VP8L && pos == whp_pkg::POS_VP8L_DONE) begin
        emit = 1'b1;
        result.status = whp_pkg::ST_OK;
        result.image_format = whp_pkg::FMT_VP8L;
        result.image_width  = 25'(word[13:0]) + 25'd1;
        result.image_height = 25'(word[27:14]) + 25'd1;
      end else if (upd.format_code == whp_pkg::FMT_VP8X &&
                   pos == whp_pkg::POS_VP8_DONE) begin
        emit = 1'b1;
        result.status = whp_pkg::ST_OK;
        result.image_format = whp_pkg::FMT_VP8X;
        result.image_width  = 25'(upd.dims_shift[23:0]) + 25'd1;
        result.image_height = 25'(upd.dims_shift[47:24]) + 25'd1;
      end else if (upd.format_code == whp_pkg::FMT_VP8 &&
                   pos == whp_pkg::POS_VP8_DONE) begin
        emit = 1'b1;
        result.status = whp_pkg::ST_OK;
        result.image_format = whp_pkg::FMT_VP8;
        result.image_width  = 25'(upd.dims_shift[29:16] & whp_pkg::DIM14_MASK);
        result.image_height = 25'(upd.dims_shift[45:32] & whp_pkg::DIM14_MASK);
      end else if (item.end_of_file) begin
        emit = 1'b1;
        result.status = whp_pkg::ST_TRUNCATED;
        result.image_format = (pos >= whp_pkg::POS_CHUNK_END) ? upd.format_code
                                                              : whp_pkg::FMT_VP8;
      end
    end

    if (s.parse_done) begin
      upd = s;
      emit = 1'b0;
      result = '0;
    end
    if (emit) begin
      upd.parse_done = 1'b1;
    end
    state_next = upd;
  end

endmodule

// ===== hdl/webp_header_dimension_parser.sv =====
// ----------------------------------------------------------------------------
// webp_header_dimension_parser
// Streams a WebP file byte by byte and reports format and image dimensions.
// ----------------------------------------------------------------------------
//  channel     | dir | payload                                        | items
//  byte_in     | in  | data_byte[7:0] first_byte end_of_file          | one per byte
//  result_out  | out | status[1:0] image_format[1:0] image_width[24:0] | one per file
//              |     | image_height[24:0]                             |
//
//  one byte per cycle sustained while no stalled result holds the bytes; a result
//  passes from its byte through the input register, then the result register
//  a stalled result blocks only the next byte that would make a result;
//  bytes that make none keep flowing through the parse state
//  rst is synchronous; after reset a byte without first_byte starts a file
// ----------------------------------------------------------------------------
module webp_header_dimension_parser (
  input logic          clk,
  input logic          rst,
  whp_byte_if.sink     byte_in,
  whp_result_if.source result_out
);

  logic                in_valid;
  whp_pkg::byte_item_t in_item;
  whp_pkg::state_t     state;
  whp_pkg::state_t     state_next;
  logic                emit;
  whp_pkg::result_t    step_result;
  logic                out_valid;
  whp_pkg::result_t    out_result;
  logic                advance;

  whp_step u_step (
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .emit       (emit),
    .result     (step_result)
  );

  assign advance = in_valid && (!emit || !out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
    if (byte_in.ready && byte_in.valid) begin
      in_item.data_byte   <= byte_in.data_byte;
      in_item.first_byte  <= byte_in.first_byte;
      in_item.end_of_file <= byte_in.end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= whp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_result <= step_result;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.status       = out_result.status;
  assign result_out.image_format = out_result.image_format;
  assign result_out.image_width  = out_result.image_width;
  assign result_out.image_height = out_result.image_height;

  // a result leaving the step stage lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("result lost on its way to the output register");

  // a finished file makes no further result until a new first byte
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && state.parse_done && !in_item.first_byte |-> !emit)
    else $error("second result for one file");

  // an open parse always finishes before the position saturates
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    !state.parse_done |-> state.byte_position != whp_pkg::POS_MAX)
    else $error("byte position saturated during an open parse");

  // lossless and extended dimensions carry a plus one and are never zero
  a_dims_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.status == whp_pkg::ST_OK &&
    out_result.image_format != whp_pkg::FMT_VP8 |->
    out_result.image_width != 25'd0 && out_result.image_height != 25'd0)
    else $error("zero dimension on a lossless or extended result");

endmodule
